// ===== design/pfc_pkg.sv =====
// shared types, constants and a function for the packet frame checker
`default_nettype none

package pfc_pkg;

	localparam int HEADER_BYTES = 13;
	localparam int COUNT_W      = 17;
	localparam int CFG_DATA_W   = 17;
	localparam int CFG_INDEX_W  = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
	localparam logic [COUNT_W-1:0] HEADER_LEN = COUNT_W'(HEADER_BYTES);

	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TYPE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DATA  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAME = 2'd2;

	localparam logic [7:0]         RST_MAX_TYPE  = 8'd255;
	localparam logic [15:0]        RST_MAX_DATA  = 16'd1024;
	localparam logic [COUNT_W-1:0] RST_MAX_FRAME = 17'd1037;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_SHORT    = 3'd1;
	localparam logic [2:0] ERR_LONG     = 3'd2;
	localparam logic [2:0] ERR_TYPE     = 3'd3;
	localparam logic [2:0] ERR_SIZE     = 3'd4;
	localparam logic [2:0] ERR_MISMATCH = 3'd5;
	localparam logic [2:0] ERR_CHECKSUM = 3'd6;

	typedef struct packed {
		logic [7:0]         max_type;
		logic [15:0]        max_data;
		logic [COUNT_W-1:0] max_frame;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] len;
		logic [15:0]        sum;
		logic [7:0]         pend;
		logic [31:0]        conn;
		logic [31:0]        pkt;
		logic [15:0]        chk;
		logic [15:0]        size;
		logic [7:0]         mtype;
	} snap_t;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

`default_nettype wire

// ===== design/pfc_accum.sv =====
// per-frame header capture and running one's-complement sum, snapshot on the last beat
`default_nettype none

module pfc_accum (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          beat_go,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          frame_end,
	input  wire logic          s2_ready,
	output pfc_pkg::snap_t     snap_s2,
	output logic               snap_valid_s2
);

	logic [pfc_pkg::COUNT_W-1:0] count_q;
	logic [15:0]                 sum_q;
	logic [7:0]                  pend_q;
	logic [31:0]                 conn_q;
	logic [31:0]                 pkt_q;
	logic [15:0]                 chk_q;
	logic [15:0]                 size_q;
	logic [7:0]                  type_q;

	pfc_pkg::snap_t nxt;
	logic [7:0]     sb;

	always_comb begin
		nxt.len   = count_q;
		nxt.sum   = sum_q;
		nxt.pend  = pend_q;
		nxt.conn  = conn_q;
		nxt.pkt   = pkt_q;
		nxt.chk   = chk_q;
		nxt.size  = size_q;
		nxt.mtype = type_q;
		sb = (count_q == 17'd8 || count_q == 17'd9) ? 8'd0 : rx_byte;
		if (count_q != pfc_pkg::COUNT_MAX) begin
			if (count_q < 17'd4) begin
				nxt.conn[8*count_q[1:0] +: 8] = rx_byte;
			end else if (count_q < 17'd8) begin
				nxt.pkt[8*count_q[1:0] +: 8] = rx_byte;
			end else if (count_q < 17'd10) begin
				nxt.chk[8*count_q[0] +: 8] = rx_byte;
			end else if (count_q < 17'd12) begin
				nxt.size[8*count_q[0] +: 8] = rx_byte;
			end else if (count_q == 17'd12) begin
				nxt.mtype = rx_byte;
			end
			if (!count_q[0]) begin
				nxt.pend = sb;
			end else begin
				nxt.sum = pfc_pkg::ones_add(sum_q, {pend_q, sb});
			end
			nxt.len = count_q + 17'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			pend_q  <= '0;
			conn_q  <= '0;
			pkt_q   <= '0;
			chk_q   <= '0;
			size_q  <= '0;
			type_q  <= '0;
		end else if (beat_go) begin
			if (frame_end) begin
				count_q <= '0;
				sum_q   <= '0;
				pend_q  <= '0;
				conn_q  <= '0;
				pkt_q   <= '0;
				chk_q   <= '0;
				size_q  <= '0;
				type_q  <= '0;
			end else begin
				count_q <= nxt.len;
				sum_q   <= nxt.sum;
				pend_q  <= nxt.pend;
				conn_q  <= nxt.conn;
				pkt_q   <= nxt.pkt;
				chk_q   <= nxt.chk;
				size_q  <= nxt.size;
				type_q  <= nxt.mtype;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			snap_valid_s2 <= beat_go && frame_end;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_go && frame_end) begin
			snap_s2 <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== design/pfc_verdict.sv =====
// frame checks in priority order and the result register
`default_nettype none

module pfc_verdict (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pfc_pkg::cfg_t  cfg,
	input  wire pfc_pkg::snap_t snap_s2,
	input  wire logic           snap_valid_s2,
	output logic                s2_ready,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic                frame_ok,
	output logic [2:0]          error_code,
	output logic [31:0]         connection_id,
	output logic [31:0]         packet_id,
	output logic [15:0]         payload_size,
	output logic [7:0]          message_type
);

	logic [15:0] fsum;
	logic [2:0]  code;
	logic        ok;

	assign s2_ready = !out_valid || !out_stall;

	always_comb begin
		fsum = snap_s2.sum;
		if (snap_s2.len[0]) begin
			fsum = pfc_pkg::ones_add(snap_s2.sum, {snap_s2.pend, 8'd0});
		end
		if (snap_s2.len < pfc_pkg::HEADER_LEN) begin
			code = pfc_pkg::ERR_SHORT;
		end else if (snap_s2.len > cfg.max_frame) begin
			code = pfc_pkg::ERR_LONG;
		end else if (snap_s2.mtype > cfg.max_type) begin
			code = pfc_pkg::ERR_TYPE;
		end else if (snap_s2.size > cfg.max_data) begin
			code = pfc_pkg::ERR_SIZE;
		end else if ({1'b0, snap_s2.size} != (snap_s2.len - pfc_pkg::HEADER_LEN)) begin
			code = pfc_pkg::ERR_MISMATCH;
		end else if (~fsum != snap_s2.chk) begin
			code = pfc_pkg::ERR_CHECKSUM;
		end else begin
			code = pfc_pkg::ERR_NONE;
		end
		ok = (code == pfc_pkg::ERR_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s2_ready) begin
			out_valid <= snap_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && snap_valid_s2) begin
			frame_ok      <= ok;
			error_code    <= code;
			connection_id <= ok ? snap_s2.conn  : 32'd0;
			packet_id     <= ok ? snap_s2.pkt   : 32'd0;
			payload_size  <= ok ? snap_s2.size  : 16'd0;
			message_type  <= ok ? snap_s2.mtype : 8'd0;
		end
	end

endmodule

`default_nettype wire

// ===== design/packet_frame_checker.sv =====
// top level of the packet frame checker: input register, config registers, stage wiring
`default_nettype none

// Takes one frame byte per beat and can accept a beat in every cycle; bytes that are
// not the last of a frame keep flowing even while a verdict waits at the output.
// Each byte passes an input register, then the accumulator stage (one 16-bit
// end-around-carry add), then the check stage that loads the result register. The
// last byte of a frame waits in the input register only while the result register
// is still holding an earlier verdict that has not been taken. Header fields in the
// result are zero on any error.
module packet_frame_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wen,
	input  wire logic [pfc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [pfc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [7:0]                        rx_byte,
	input  wire logic                              frame_end,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   frame_ok,
	output logic [2:0]                             error_code,
	output logic [31:0]                            connection_id,
	output logic [31:0]                            packet_id,
	output logic [15:0]                            payload_size,
	output logic [7:0]                             message_type
);

	pfc_pkg::cfg_t  cfg_q;
	pfc_pkg::snap_t snap_s2;
	logic           snap_valid_s2;
	logic           s2_ready;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       go_s1;
	logic       ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_type  <= pfc_pkg::RST_MAX_TYPE;
			cfg_q.max_data  <= pfc_pkg::RST_MAX_DATA;
			cfg_q.max_frame <= pfc_pkg::RST_MAX_FRAME;
		end else if (cfg_wen) begin
			case (cfg_index)
				pfc_pkg::CFG_MAX_TYPE:  cfg_q.max_type  <= cfg_data[7:0];
				pfc_pkg::CFG_MAX_DATA:  cfg_q.max_data  <= cfg_data[15:0];
				pfc_pkg::CFG_MAX_FRAME: cfg_q.max_frame <= cfg_data;
				default: ;
			endcase
		end
	end

	// a last beat needs room in the check stage, other beats never wait
	assign go_s1    = valid_s1 && (!end_s1 || s2_ready);
	assign ready_s1 = !valid_s1 || go_s1;
	assign in_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			byte_s1 <= rx_byte;
			end_s1  <= frame_end;
		end
	end

	pfc_accum u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.beat_go       (go_s1),
		.rx_byte       (byte_s1),
		.frame_end     (end_s1),
		.s2_ready      (s2_ready),
		.snap_s2       (snap_s2),
		.snap_valid_s2 (snap_valid_s2)
	);

	pfc_verdict u_verdict (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.snap_s2       (snap_s2),
		.snap_valid_s2 (snap_valid_s2),
		.s2_ready      (s2_ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_ok      (frame_ok),
		.error_code    (error_code),
		.connection_id (connection_id),
		.packet_id     (packet_id),
		.payload_size  (payload_size),
		.message_type  (message_type)
	);

endmodule

`default_nettype wire

// ===== tb/packet_frame_checker_tb.sv =====
// testbench for packet_frame_checker: frames streamed as byte beats, verdicts checked against a predictor
`timescale 1ns / 100ps

module packet_frame_checker_tb;
	import pfc_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

	typedef enum int {PACE_FULL, PACE_RANDOM, PACE_SPARSE} pace_t;

	typedef struct packed {
		logic        ok;
		logic [2:0]  code;
		logic [31:0] conn;
		logic [31:0] pkt;
		logic [15:0] size;
		logic [7:0]  mtype;
	} verdict_t;

	typedef struct packed {
		logic [COUNT_W-1:0] len;
		logic [15:0]        sum;
		logic [7:0]         pend;
		logic [31:0]        conn;
		logic [31:0]        pkt;
		logic [15:0]        chk;
		logic [15:0]        size;
		logic [7:0]         mtype;
	} frame_acc_t;

	typedef struct {
		logic [31:0] conn;
		logic [31:0] pkt;
		logic [15:0] size;
		logic [7:0]  mtype;
		int          plen;
		int          cut;
		bit          good_chk;
		bit          typed;
		logic [2:0]  want_code;
	} frame_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wen;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [7:0]             rx_byte;
	logic                   frame_end;
	logic                   out_valid;
	logic                   out_stall;
	logic                   frame_ok;
	logic [2:0]             error_code;
	logic [31:0]            connection_id;
	logic [31:0]            packet_id;
	logic [15:0]            payload_size;
	logic [7:0]             message_type;

	verdict_t           verdict_q[$];
	frame_acc_t         acc;
	logic [7:0]         lim_type;
	logic [15:0]        lim_data;
	logic [COUNT_W-1:0] lim_frame;
	verdict_t           typed_want;
	bit                 typed_pending;
	verdict_t           got_v;
	verdict_t           want_v;
	pace_t              src_mode;
	pace_t              sink_mode;
	int                 out_hold;
	int                 fails;
	int                 beats_taken;
	int                 verdicts_due;

	packet_frame_checker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.frame_end     (frame_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_ok      (frame_ok),
		.error_code    (error_code),
		.connection_id (connection_id),
		.packet_id     (packet_id),
		.payload_size  (payload_size),
		.message_type  (message_type)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	function automatic int draw_gap(input pace_t mode);
		case (mode)
			PACE_FULL: return 0;
			PACE_RANDOM: return int'($urandom_range(0, 15));
			default: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 15)) : 0;
		endcase
	endfunction

	task automatic note_miss(input string what, input verdict_t want, input verdict_t got);
		fails++;
		if (fails <= 10) begin
			$display("%0t %s", $time, what);
			$display("  expected ok=%0d code=%0d conn=%h pkt=%h size=%0d type=%0d",
				want.ok, want.code, want.conn, want.pkt, want.size, want.mtype);
			$display("  actual   ok=%0d code=%0d conn=%h pkt=%h size=%0d type=%0d",
				got.ok, got.code, got.conn, got.pkt, got.size, got.mtype);
		end
	endtask

	// predictor: folds one accepted beat into the frame state, queues the verdict on the last
	task automatic take_byte(input logic [7:0] b, input logic last);
		logic [COUNT_W-1:0] pos;
		logic [7:0]         sb;
		logic [15:0]        sum;
		verdict_t           v;
		beats_taken++;
		if (acc.len != COUNT_MAX) begin
			pos = acc.len;
			sb = (pos == 8 || pos == 9) ? 8'h00 : b;
			if (pos < 4)
				acc.conn[8*pos[1:0] +: 8] = b;
			else if (pos < 8)
				acc.pkt[8*pos[1:0] +: 8] = b;
			else if (pos < 10)
				acc.chk[8*pos[0] +: 8] = b;
			else if (pos < 12)
				acc.size[8*pos[0] +: 8] = b;
			else if (pos == 12)
				acc.mtype = b;
			if (!pos[0])
				acc.pend = sb;
			else
				acc.sum = fold_add(acc.sum, {acc.pend, sb});
			acc.len = pos + 1'b1;
		end
		if (last) begin
			sum = acc.sum;
			if (acc.len[0])
				sum = fold_add(sum, {acc.pend, 8'h00});
			v = '0;
			if (acc.len < HEADER_LEN)
				v.code = ERR_SHORT;
			else if (acc.len > lim_frame)
				v.code = ERR_LONG;
			else if (acc.mtype > lim_type)
				v.code = ERR_TYPE;
			else if (acc.size > lim_data)
				v.code = ERR_SIZE;
			else if ({1'b0, acc.size} != acc.len - HEADER_LEN)
				v.code = ERR_MISMATCH;
			else if (~sum != acc.chk)
				v.code = ERR_CHECKSUM;
			else
				v = '{1'b1, ERR_NONE, acc.conn, acc.pkt, acc.size, acc.mtype};
			verdict_q.push_back(typed_pending ? typed_want : v);
			typed_pending = 1'b0;
			verdicts_due++;
			acc = '0;
		end
	endtask

	task automatic send_beat(input logic [7:0] b, input logic last, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		rx_byte = b;
		frame_end = last;
		do @(posedge clk); while (in_stall);
		take_byte(b, last);
	endtask

	task automatic send_frame(ref logic [7:0] fr[$], input bit rush);
		src_mode = rush ? PACE_FULL : pace_t'($urandom_range(0, 2));
		foreach (fr[i])
			send_beat(fr[i], i == fr.size() - 1, draw_gap(src_mode));
	endtask

	task automatic build_frame(ref logic [7:0] fr[$], input logic [31:0] conn,
			input logic [31:0] pkt, input logic [15:0] size, input logic [7:0] mtype,
			input int plen, input bit good_chk);
		logic [15:0] sum;
		logic [15:0] chk;
		fr = {};
		for (int i = 0; i < 4; i++)
			fr.push_back(conn[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			fr.push_back(pkt[8*i +: 8]);
		fr.push_back(8'h00);
		fr.push_back(8'h00);
		fr.push_back(size[7:0]);
		fr.push_back(size[15:8]);
		fr.push_back(mtype);
		repeat (plen) fr.push_back(8'($urandom));
		sum = 16'h0000;
		for (int i = 0; i < fr.size(); i += 2)
			sum = fold_add(sum, {fr[i], (i + 1 < fr.size()) ? fr[i + 1] : 8'h00});
		chk = ~sum;
		if (!good_chk)
			chk = chk ^ (16'd1 << $urandom_range(0, 15));
		fr[8] = chk[7:0];
		fr[9] = chk[15:8];
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wen = 1'b0;
		case (idx)
			CFG_MAX_TYPE: lim_type = val[7:0];
			CFG_MAX_DATA: lim_data = val[15:0];
			CFG_MAX_FRAME: lim_frame = val;
			default: ;
		endcase
	endtask

	// sender holds off until every verdict is in, then the pipe gets time to empty
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_frame();
		logic [7:0] fr[$];
		int         pick;
		int         lim;
		int         size;
		int         plen;
		pick = $urandom_range(0, 99);
		lim = int'(lim_data);
		if (int'(lim_frame) - HEADER_BYTES < lim)
			lim = int'(lim_frame) - HEADER_BYTES;
		if (lim > 24 && $urandom_range(0, 9) != 0)
			lim = 24;
		else if (lim > 300)
			lim = 300;
		size = $urandom_range(0, lim);
		if (pick < 80) begin
			build_frame(fr, $urandom, $urandom, 16'(size), 8'($urandom_range(0, lim_type)),
				size, pick < 70);
		end else if (pick < 86) begin
			plen = (size > 0 && $urandom_range(0, 1) == 1) ? size - 1 : size + $urandom_range(1, 3);
			build_frame(fr, $urandom, $urandom, 16'(size), 8'($urandom_range(0, lim_type)),
				plen, 1'b1);
		end else if (pick < 92) begin
			build_frame(fr, $urandom, $urandom, 16'($urandom), 8'($urandom),
				$urandom_range(0, 20), $urandom_range(0, 1) == 1);
		end else begin
			// junk: random bytes cut off at a random point
			repeat ($urandom_range(1, 30)) fr.push_back(8'($urandom));
		end
		send_frame(fr, 1'b0);
	endtask

	task automatic random_phase(input int beats);
		int beat_mark;
		int verdict_mark;
		beat_mark = beats_taken + beats;
		verdict_mark = verdicts_due + 12;
		while (beats_taken < beat_mark || verdicts_due < verdict_mark)
			random_frame();
		settle();
	endtask

	always @(negedge clk) begin
		if (out_hold > 0) begin
			out_stall = 1'b1;
			out_hold--;
		end else begin
			out_stall = 1'b0;
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			got_v = '{frame_ok, error_code, connection_id, packet_id, payload_size, message_type};
			if (verdict_q.size() == 0) begin
				note_miss("verdict with none pending", '0, got_v);
			end else begin
				want_v = verdict_q.pop_front();
				if (got_v !== want_v)
					note_miss("verdict mismatch", want_v, got_v);
			end
			if ($urandom_range(0, 15) == 0)
				sink_mode = pace_t'($urandom_range(0, 2));
			out_hold = draw_gap(sink_mode);
		end
	end

	initial begin
		#16_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		frame_row_t rows [14];
		logic [7:0] fr[$];
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = CFG_MAX_TYPE;
		cfg_data = '0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		frame_end = 1'b0;
		out_stall = 1'b0;
		out_hold = 0;
		sink_mode = PACE_RANDOM;
		src_mode = PACE_RANDOM;
		typed_pending = 1'b0;
		typed_want = '0;
		fails = 0;
		beats_taken = 0;
		verdicts_due = 0;
		acc = '0;
		lim_type = RST_MAX_TYPE;
		lim_data = RST_MAX_DATA;
		lim_frame = RST_MAX_FRAME;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed frames, limits lowered so bad type, oversize and long frames stay short
		write_reg(CFG_MAX_TYPE, 17'd200);
		write_reg(CFG_MAX_DATA, 17'd20);
		write_reg(CFG_MAX_FRAME, 17'd33);
		rows = '{
			'{32'h0000_0000, 32'h0000_0000, 16'd0,     8'd0,   0,    1,  1, 1, ERR_SHORT},
			'{32'h1234_5678, 32'h9abc_def0, 16'd0,     8'd0,   0,    12, 1, 1, ERR_SHORT},
			'{32'h0000_0000, 32'h0000_0000, 16'd0,     8'd0,   0,    0,  1, 0, ERR_NONE},
			'{32'hffff_ffff, 32'hffff_ffff, 16'd1,     8'd200, 1,    0,  1, 0, ERR_NONE},
			'{32'ha5a5_5a5a, 32'h0f0f_f0f0, 16'd2,     8'd0,   2,    0,  1, 0, ERR_NONE},
			'{32'h0102_0304, 32'h0506_0708, 16'd4,     8'd7,   4,    0,  0, 1, ERR_CHECKSUM},
			'{32'h1111_1111, 32'h2222_2222, 16'd0,     8'd201, 0,    0,  1, 1, ERR_TYPE},
			'{32'h3333_3333, 32'h4444_4444, 16'd3,     8'd255, 3,    0,  1, 1, ERR_TYPE},
			'{32'h5555_5555, 32'h6666_6666, 16'd21,    8'd1,   3,    0,  1, 1, ERR_SIZE},
			'{32'h7777_7777, 32'h8888_8888, 16'hffff,  8'd1,   0,    0,  1, 1, ERR_SIZE},
			'{32'h9999_9999, 32'haaaa_aaaa, 16'd5,     8'd2,   4,    0,  1, 1, ERR_MISMATCH},
			'{32'hdead_beef, 32'hcafe_f00d, 16'd20,    8'd9,   20,   0,  1, 0, ERR_NONE},
			'{32'hbbbb_bbbb, 32'hcccc_cccc, 16'd20,    8'd9,   21,   0,  1, 1, ERR_LONG},
			'{32'h8000_0001, 32'h7fff_fffe, 16'd10,    8'd3,   10,   0,  1, 0, ERR_NONE}
		};
		foreach (rows[i]) begin
			build_frame(fr, rows[i].conn, rows[i].pkt, rows[i].size, rows[i].mtype,
				rows[i].plen, rows[i].good_chk);
			if (rows[i].cut > 0)
				while (fr.size() > rows[i].cut) void'(fr.pop_back());
			typed_want = '{1'b0, rows[i].want_code, 32'd0, 32'd0, 16'd0, 8'd0};
			typed_pending = rows[i].typed;
			send_frame(fr, 1'b0);
		end
		settle();
		write_reg(CFG_MAX_DATA, 17'(RST_MAX_DATA));
		write_reg(CFG_MAX_FRAME, RST_MAX_FRAME);
		random_phase(170);

		write_reg(CFG_MAX_TYPE, 17'($urandom_range(0, 255)));
		write_reg(CFG_MAX_DATA, 17'($urandom_range(0, 600)));
		write_reg(CFG_MAX_FRAME, 17'(HEADER_BYTES + $urandom_range(0, 600)));
		write_reg(CFG_SPARE, 17'($urandom));
		random_phase(170);

		// tightest limits; upper data bits must be dropped
		write_reg(CFG_MAX_TYPE, 17'h1_5a00);
		write_reg(CFG_MAX_DATA, 17'd0);
		write_reg(CFG_MAX_FRAME, 17'(HEADER_BYTES));
		random_phase(160);

		write_reg(CFG_MAX_TYPE, 17'h1_ffff);
		write_reg(CFG_MAX_DATA, 17'h1_ffff);
		write_reg(CFG_MAX_FRAME, 17'd65548);
		random_phase(170);

		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/pfc_pkg.sv
design/pfc_accum.sv
design/pfc_verdict.sv
design/packet_frame_checker.sv
tb/packet_frame_checker_tb.sv
